[rtl/tkr_pkg.sv]
// Shared types and constants for the terminal key router.
// Used by every module of the block but tkr_ram, and by its port checker.
package tkr_pkg;

  localparam int TERMINALS   = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int TERM_W = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = TERMINALS * QUEUE_DEPTH;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [BYTE_W-1:0] KEY_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] KEY_O   = 8'h4F;
  localparam logic [BYTE_W-1:0] KEY_P   = 8'h50;
  localparam logic [BYTE_W-1:0] KEY_S   = 8'h53;

  typedef enum logic [1:0] {
    OP_RECV   = 2'd0,
    OP_READ   = 2'd1,
    OP_CHANGE = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_PENDING    = 3'd2,
    ST_SWITCHED   = 3'd3,
    ST_SAME       = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_READ_EMPTY = 3'd6,
    ST_CHANGED    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_GOT_1 = 2'd1,
    ESC_GOT_2 = 2'd2
  } esc_state_t;

  // Decision of the escape detector for one received byte.
  typedef struct packed {
    logic              push_req;
    logic              switch_en;
    logic [TERM_W-1:0] sel;
    status_t           status;
  } esc_dec_t;

  // Queue requests from the top level to the pointer block.
  typedef struct packed {
    logic              push;
    logic [TERM_W-1:0] push_term;
    logic              pop;
    logic [TERM_W-1:0] pop_term;
  } q_req_t;

  // Queue status back to the top level.
  typedef struct packed {
    logic              full;
    logic              has_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } q_stat_t;

endpackage

[rtl/tkr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module tkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/tkr_esc.sv]
// Escape sequence detector: ESC 'O' then P/Q/R/S selects a terminal.
// Depends on tkr_pkg.
module tkr_esc import tkr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [TERM_W-1:0] active_term,
  output esc_dec_t          dec
);

  esc_state_t state;
  esc_state_t state_next;
  logic [BYTE_W-1:0] sel_full;

  assign sel_full = data_byte - KEY_P;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ESC_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = ESC_IDLE;
    dec.push_req  = 1'b1;
    dec.switch_en = 1'b0;
    dec.sel       = sel_full[TERM_W-1:0];
    dec.status    = ST_QUEUED;
    unique case (state)
      ESC_IDLE: begin
        if (data_byte == KEY_ESC) begin
          state_next   = ESC_GOT_1;
          dec.push_req = 1'b0;
          dec.status   = ST_PENDING;
        end
      end
      ESC_GOT_1: begin
        if (data_byte == KEY_O) begin
          state_next   = ESC_GOT_2;
          dec.push_req = 1'b0;
          dec.status   = ST_PENDING;
        end
      end
      ESC_GOT_2: begin
        if (data_byte >= KEY_P && data_byte <= KEY_S) begin
          dec.push_req = 1'b0;
          if (int'(sel_full) >= TERMINALS || sel_full[TERM_W-1:0] == active_term) begin
            dec.status = ST_SAME;
          end else begin
            dec.switch_en = 1'b1;
            dec.status    = ST_SWITCHED;
          end
        end
      end
      default: begin
        state_next = ESC_IDLE;
      end
    endcase
  end

endmodule

[rtl/tkr_qptr.sv]
// Per-terminal ring queue pointers and fill levels, plus store addresses.
// Depends on tkr_pkg.
module tkr_qptr import tkr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_req_t  req,
  output q_stat_t stat
);

  logic [IDX_W-1:0]  wr_idx [TERMINALS];
  logic [IDX_W-1:0]  rd_idx [TERMINALS];
  logic [FILL_W-1:0] fill   [TERMINALS];

  assign stat.full     = (fill[req.push_term] == FILL_W'(QUEUE_DEPTH));
  assign stat.has_data = (fill[req.pop_term] != '0);
  assign stat.wr_addr  = ADDR_W'(req.push_term) * ADDR_W'(QUEUE_DEPTH)
                       + ADDR_W'(wr_idx[req.push_term]);
  assign stat.rd_addr  = ADDR_W'(req.pop_term) * ADDR_W'(QUEUE_DEPTH)
                       + ADDR_W'(rd_idx[req.pop_term]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TERMINALS; i++) begin
        wr_idx[i] <= '0;
        rd_idx[i] <= '0;
        fill[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < TERMINALS; i++) begin
        if (req.push && req.push_term == TERM_W'(i)) begin
          wr_idx[i] <= (wr_idx[i] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx[i] + 1'b1;
          fill[i]   <= fill[i] + 1'b1;
        end else if (req.pop && req.pop_term == TERM_W'(i)) begin
          rd_idx[i] <= (rd_idx[i] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx[i] + 1'b1;
          fill[i]   <= fill[i] - 1'b1;
        end
      end
    end
  end

endmodule

[rtl/terminal_key_router_fifos_top.sv]
// Top level of the terminal key router: escape detector, queue pointers,
// byte store and result register. Depends on tkr_pkg, tkr_esc, tkr_qptr, tkr_ram.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one operation per
//   transfer: opcode 0 delivers a received serial byte in data_byte,
//   opcode 1 pops one byte from the queue of the terminal named in
//   terminal, opcode 2 makes that terminal the current one.
//   The output channel (out_valid / out_stall) returns exactly one result
//   per input transfer: a status code, the popped byte (zero unless the
//   read succeeded) and the terminal that is current after the operation.
//   A result is offered in the cycle after its input transfer. Throughput
//   is one item per clock unless stalled; the escape decision and the
//   pointer update complete in the cycle the item is taken, and the store's
//   registered read output serves as the read_byte result register.
//   While a result waits with out_stall high, in_stall is raised and
//   nothing moves; the result and the store output hold until taken.
//   Synchronous reset clears the escape detector, selects terminal 0,
//   empties all four queues and drops any pending result. No clearing
//   pass is needed: the store is only read at entries already written.
module terminal_key_router_fifos_top import tkr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [TERM_W-1:0] terminal,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [BYTE_W-1:0] read_byte,
  output logic [TERM_W-1:0] current_terminal
);

  logic              accept;
  logic [TERM_W-1:0] active_term;
  logic [TERM_W-1:0] active_term_next;
  logic              term_ok;
  logic              is_recv;
  logic              do_pop;
  status_t           status_next;
  status_t           status_reg;
  logic              is_read_reg;
  esc_dec_t          esc_dec;
  q_req_t            q_req;
  q_stat_t           q_stat;
  logic [BYTE_W-1:0] ram_q;

  // The single result register parts the two channels; a new item is taken
  // whenever that register is empty or is being drained this cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign term_ok = int'(terminal) < TERMINALS;
  assign is_recv = (opcode == OP_RECV);

  tkr_esc u_esc (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept && is_recv),
    .data_byte   (data_byte),
    .active_term (active_term),
    .dec         (esc_dec)
  );

  assign do_pop = (opcode == OP_READ) && term_ok && q_stat.has_data;

  assign q_req.push      = accept && is_recv && esc_dec.push_req && !q_stat.full;
  assign q_req.push_term = active_term;
  assign q_req.pop       = accept && do_pop;
  assign q_req.pop_term  = terminal;

  tkr_qptr u_qptr (
    .clk  (clk),
    .rst  (rst),
    .req  (q_req),
    .stat (q_stat)
  );

  // The read port only fires on a pop, so its output holds the popped byte
  // for as long as the result waits.
  tkr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (q_req.push),
    .wr_addr (q_stat.wr_addr),
    .wr_data (data_byte),
    .rd_en   (q_req.pop),
    .rd_addr (q_stat.rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    status_next      = ST_SAME;
    active_term_next = active_term;
    case (opcode)
      OP_RECV: begin
        if (esc_dec.push_req) begin
          status_next = q_stat.full ? ST_DROPPED : ST_QUEUED;
        end else begin
          status_next = esc_dec.status;
          if (esc_dec.switch_en) begin
            active_term_next = esc_dec.sel;
          end
        end
      end
      OP_READ: begin
        status_next = do_pop ? ST_READ_OK : ST_READ_EMPTY;
      end
      OP_CHANGE: begin
        if (term_ok) begin
          status_next      = ST_CHANGED;
          active_term_next = terminal;
        end
      end
      default: begin
        status_next = ST_SAME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_term <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        active_term <= active_term_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg       <= status_next;
      is_read_reg      <= do_pop;
      current_terminal <= active_term_next;
    end
  end

  assign status    = status_reg;
  assign read_byte = is_read_reg ? ram_q : '0;

endmodule

[rtl/tkr_checker.sv]
// Port-level checker for the terminal key router, bound to the top level.
// Depends on tkr_pkg and terminal_key_router_fifos_top.
module tkr_checker import tkr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        status,
  input logic [BYTE_W-1:0] read_byte,
  input logic [TERM_W-1:0] current_terminal
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_byte)
      && $stable(current_terminal))
    else $error("stalled result changed");

  // The input side only waits behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Every input transfer yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // Only a successful read carries a byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_READ_OK |-> read_byte == '0)
    else $error("nonzero read_byte without a successful read");

  // Reset empties the result register.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind terminal_key_router_fifos_top tkr_checker u_tkr_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .status           (status),
  .read_byte        (read_byte),
  .current_terminal (current_terminal)
);
